@@ rtl/core/bbc_pkg.sv @@
// shared types, constants and conversion functions for the bisulfite base converter
package bbc_pkg;

    localparam logic [7:0] CHAR_LC_C = 8'h63;
    localparam logic [7:0] CHAR_UC_C = 8'h43;
    localparam logic [7:0] CHAR_LC_G = 8'h67;
    localparam logic [7:0] CHAR_UC_G = 8'h47;
    localparam logic [7:0] CHAR_UC_T = 8'h54;
    localparam logic [7:0] CHAR_UC_A = 8'h41;

    // configuration register indexes
    localparam logic CFG_DIRECTION = 1'b0;
    localparam logic CFG_VARIANT   = 1'b1;

    // variant codes
    localparam logic [1:0] VARIANT_CONTEXT = 2'd0;
    localparam logic [1:0] VARIANT_ISLAND  = 2'd1;

    // result queue depth and derived widths
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [7:0] base_in;
        logic       in_island;
        logic       last_in;
    } bbc_in_t;

    typedef struct packed {
        logic [7:0] base_out;
        logic       last_out;
    } bbc_out_t;

    // results produced by one item, up to two
    typedef struct packed {
        logic [1:0] num;
        bbc_out_t   first;
        bbc_out_t   second;
    } bbc_push_t;

    function automatic logic is_c(input logic [7:0] b);
        return (b == CHAR_LC_C) || (b == CHAR_UC_C);
    endfunction

    function automatic logic is_g(input logic [7:0] b);
        return (b == CHAR_LC_G) || (b == CHAR_UC_G);
    endfunction

    function automatic logic [7:0] conv_ct(input logic [7:0] b, input logic isl,
                                           input logic next_g, input logic [1:0] variant);
        logic [7:0] r;
        r = b;
        if (is_c(b))
        begin
            if (!next_g || variant[1] || (variant == VARIANT_ISLAND && isl))
            begin
                r = CHAR_UC_T;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] conv_ga(input logic [7:0] b, input logic prev_c,
                                           input logic pisl, input logic [1:0] variant);
        logic [7:0] r;
        r = b;
        if (is_g(b))
        begin
            if (!prev_c || variant[1] || (variant == VARIANT_ISLAND && pisl))
            begin
                r = CHAR_UC_A;
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/bbc_convert.sv @@
// input register, neighbor context state and per-base conversion logic
module bbc_convert
    import bbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  bbc_in_t    item_data,
    input  logic       direction,
    input  logic [1:0] variant,
    input  logic       space,
    output bbc_push_t  push
);

    logic       in_valid_reg, in_valid_next;
    bbc_in_t    in_data_reg;
    logic [7:0] held_base_reg, held_base_next;
    logic       held_valid_reg, held_valid_next;
    logic       held_island_reg, held_island_next;
    logic       prev_was_c_reg, prev_was_c_next;
    logic       prev_island_reg, prev_island_next;
    logic       have_prev_reg, have_prev_next;

    logic       advance;
    logic       accept;
    logic       cur_emit;
    bbc_out_t   held_res;
    bbc_out_t   cur_res;

    assign advance    = in_valid_reg && space;
    assign item_stall = in_valid_reg && !space;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        held_res.base_out = conv_ct(held_base_reg, held_island_reg,
                                    is_g(in_data_reg.base_in), variant);
        held_res.last_out = 1'b0;

        if (direction)
        begin
            cur_emit          = in_data_reg.last_in;
            cur_res.base_out  = conv_ct(in_data_reg.base_in, in_data_reg.in_island,
                                        1'b0, variant);
            cur_res.last_out  = 1'b1;
        end
        else
        begin
            cur_emit          = 1'b1;
            cur_res.base_out  = conv_ga(in_data_reg.base_in, have_prev_reg && prev_was_c_reg,
                                        prev_island_reg, variant);
            cur_res.last_out  = in_data_reg.last_in;
        end

        push.num    = advance ? ({1'b0, held_valid_reg} + {1'b0, cur_emit}) : 2'd0;
        push.first  = held_valid_reg ? held_res : cur_res;
        push.second = cur_res;

        in_valid_next    = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        held_base_next   = held_base_reg;
        held_island_next = held_island_reg;
        held_valid_next  = held_valid_reg;
        prev_was_c_next  = prev_was_c_reg;
        prev_island_next = prev_island_reg;
        have_prev_next   = have_prev_reg;

        if (advance)
        begin
            // a held C-to-T base is always resolved against this base
            held_valid_next = direction && !in_data_reg.last_in;
            if (direction && !in_data_reg.last_in)
            begin
                held_base_next   = in_data_reg.base_in;
                held_island_next = in_data_reg.in_island;
            end
            if (in_data_reg.last_in)
            begin
                have_prev_next   = 1'b0;
                prev_was_c_next  = 1'b0;
                prev_island_next = 1'b0;
            end
            else
            begin
                have_prev_next   = 1'b1;
                prev_was_c_next  = is_c(in_data_reg.base_in);
                prev_island_next = in_data_reg.in_island;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            held_base_reg   <= '0;
            held_valid_reg  <= 1'b0;
            held_island_reg <= 1'b0;
            prev_was_c_reg  <= 1'b0;
            prev_island_reg <= 1'b0;
            have_prev_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            held_base_reg   <= held_base_next;
            held_valid_reg  <= held_valid_next;
            held_island_reg <= held_island_next;
            prev_was_c_reg  <= prev_was_c_next;
            prev_island_reg <= prev_island_next;
            have_prev_reg   <= have_prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= item_data;
        end
    end

endmodule

@@ rtl/core/bbc_out_fifo.sv @@
// small result queue taking up to two results per cycle and giving one per cycle while result_stall is low
module bbc_out_fifo
    import bbc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bbc_push_t push,
    output logic      space,
    output logic      result_valid,
    input  logic      result_stall,
    output bbc_out_t  result_data
);

    bbc_out_t               entry_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0]   count_reg, count_next;
    logic [OUT_PTR_W-1:0]   wr_ptr_second;
    logic                   pop;

    // room for the worst case of two results
    assign space         = count_reg <= OUT_CNT_W'(OUT_DEPTH - 2);
    assign result_valid  = count_reg != '0;
    assign result_data   = entry_reg[rd_ptr_reg];
    assign pop           = result_valid && !result_stall;
    assign wr_ptr_second = wr_ptr_reg + OUT_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(push.num);
        rd_ptr_next = rd_ptr_reg + OUT_PTR_W'(pop);
        count_next  = count_reg + OUT_CNT_W'(push.num) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            entry_reg[wr_ptr_second] <= push.second;
        end
    end

endmodule

@@ rtl/core/bisulfite_base_converter.sv @@
// top level of the bisulfite base converter: config registers, conversion and result queue
//
//   channel   signals                                      request
//   item      item_valid / item_stall / item_data          one genome base
//   result    result_valid / result_stall / result_data    one converted base
//   config    cfg_we / cfg_index / cfg_data                register write
//
// one base per cycle while the result queue has room; a base passes the input register and
// then lands in the result queue, from which its result is taken
// in C-to-T direction a base waits for its successor, so its result trails one base
// a last base in C-to-T direction gives two results; with a free result side the queue
// takes the extra one without stalling the input
// a result queue without room for two results stalls the input register; reset empties
// both and clears context
module bisulfite_base_converter
    import bbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  bbc_in_t    item_data,
    output logic       result_valid,
    input  logic       result_stall,
    output bbc_out_t   result_data,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [1:0] cfg_data
);

    logic       direction_reg, direction_next;
    logic [1:0] variant_reg, variant_next;
    logic       space;
    bbc_push_t  push;

    always_comb
    begin
        direction_next = direction_reg;
        variant_next   = variant_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIRECTION: direction_next = cfg_data[0];
                CFG_VARIANT:   variant_next   = cfg_data;
                default:       direction_next = direction_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b1;
            variant_reg   <= VARIANT_CONTEXT;
        end
        else
        begin
            direction_reg <= direction_next;
            variant_reg   <= variant_next;
        end
    end

    bbc_convert u_convert (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .direction  (direction_reg),
        .variant    (variant_reg),
        .space      (space),
        .push       (push)
    );

    bbc_out_fifo u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .space        (space),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule
